### hdl/round_robin_quantum_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Round-robin scheduler assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_ASSERT_SVH

// Same-cycle implication
`define RRQS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("rrqs assertion failed");

// Next-cycle implication
`define RRQS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("rrqs assertion failed");

`endif

### hdl/rrqs_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin scheduler package
// Field widths, codes, controller states, command/status bundles, helpers.
// ----------------------------------------------------------------------------
package rrqs_pkg;

    // Field widths
    localparam int BURST_W  = 16;
    localparam int QUANT_W  = 8;
    localparam int ID_W     = 6;
    localparam int SLICE_W  = 8;
    localparam int TIME_W   = 22;
    localparam int SUM_W    = 32;
    localparam int COUNT_W  = 7;
    localparam int TDATA_W  = 144;
    localparam int TUSER_W  = 3;

    // Search groups: flags are scanned eight at a time
    localparam int GRP_W     = 8;
    localparam int GRP_IDX_W = 3;

    // Action codes
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // Register index of the quantum register
    localparam logic REG_QUANTUM = 1'b0;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd10;
    localparam logic [TIME_W-1:0]  TIME_MAX      = 22'h3FFFFF;
    localparam logic [SUM_W-1:0]   SUM_MAX       = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_FIND,
        ST_SEL,
        ST_EXEC,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic do_add;
        logic find;
        logic sel;
        logic exec;
        logic acc;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic found;
        logic out_free;
    } t_status;

    // Saturating 32-bit add
    function automatic logic [SUM_W-1:0] sat_add32(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

### hdl/rrqs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rrqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/rrqs_ctrl.sv
// ----------------------------------------------------------------------------
// Round-robin scheduler controller
// Sequences one item at a time through add or find/select/execute/accumulate.
// ----------------------------------------------------------------------------
module rrqs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_action,
    input  rrqs_pkg::t_status i_status,
    output logic              o_s_tready,
    output rrqs_pkg::t_cmd    o_cmd
);

    rrqs_pkg::t_state r_state;
    rrqs_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrqs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrqs_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = (i_action == rrqs_pkg::ACT_ADD) ? rrqs_pkg::ST_ADD
                                                              : rrqs_pkg::ST_FIND;
                end
            end
            rrqs_pkg::ST_ADD:  n_state = rrqs_pkg::ST_DONE;
            rrqs_pkg::ST_FIND: n_state = rrqs_pkg::ST_SEL;
            rrqs_pkg::ST_SEL: begin
                n_state = i_status.found ? rrqs_pkg::ST_EXEC : rrqs_pkg::ST_DONE;
            end
            rrqs_pkg::ST_EXEC: n_state = rrqs_pkg::ST_ACC;
            rrqs_pkg::ST_ACC:  n_state = rrqs_pkg::ST_DONE;
            rrqs_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = rrqs_pkg::ST_IDLE;
                end
            end
            default: n_state = rrqs_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_tready     = (r_state == rrqs_pkg::ST_IDLE);
        o_cmd.latch_in = (r_state == rrqs_pkg::ST_IDLE) && i_s_tvalid;
        o_cmd.do_add   = (r_state == rrqs_pkg::ST_ADD);
        o_cmd.find     = (r_state == rrqs_pkg::ST_FIND);
        o_cmd.sel      = (r_state == rrqs_pkg::ST_SEL);
        o_cmd.exec     = (r_state == rrqs_pkg::ST_EXEC);
        o_cmd.acc      = (r_state == rrqs_pkg::ST_ACC);
        o_cmd.load_out = (r_state == rrqs_pkg::ST_DONE) && i_status.out_free;
    end

`include "round_robin_quantum_scheduler_assert.svh"

    `RRQS_ASSERT_IMP(a_exec_after_sel, r_state == rrqs_pkg::ST_EXEC, $past(r_state) == rrqs_pkg::ST_SEL)
    `RRQS_ASSERT_NXT(a_empty_goes_done, o_cmd.sel && !i_status.found, r_state == rrqs_pkg::ST_DONE)

endmodule

### hdl/rrqs_dpath.sv
// ----------------------------------------------------------------------------
// Round-robin scheduler datapath
// Task table, rotating search, slice arithmetic, totals and output register.
// ----------------------------------------------------------------------------
module rrqs_dpath #(
    parameter int MAX_TASKS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rrqs_pkg::t_cmd                      i_cmd,
    output rrqs_pkg::t_status                   o_status,
    input  logic [rrqs_pkg::QUANT_W-1:0]        i_quantum,
    input  logic [rrqs_pkg::BURST_W-1:0]        i_burst,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [rrqs_pkg::TDATA_W-1:0]        o_m_tdata,
    output logic [rrqs_pkg::TUSER_W-1:0]        o_m_tuser
);

    localparam int SW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int NG = (MAX_TASKS + rrqs_pkg::GRP_W - 1) / rrqs_pkg::GRP_W;
    localparam int NP = NG * rrqs_pkg::GRP_W;
    localparam int BW = rrqs_pkg::BURST_W;
    localparam int TW = rrqs_pkg::TIME_W;
    localparam int UW = rrqs_pkg::SUM_W;
    localparam int GIW = rrqs_pkg::GRP_IDX_W;

    // Task flags and scheduler state
    logic [MAX_TASKS-1:0] r_active;
    logic [MAX_TASKS-1:0] r_started;
    logic [CW-1:0]        r_count;
    logic [SW-1:0]        r_cur;
    logic [TW-1:0]        r_time;
    logic [UW-1:0]        r_resp;
    logic [UW-1:0]        r_turn;
    logic [UW-1:0]        r_wait;
    logic [BW-1:0]        r_burst;

    // Search group registers
    logic           r_ghi_any [NG];
    logic [GIW-1:0] r_ghi_idx [NG];
    logic           r_gal_any [NG];
    logic [GIW-1:0] r_gal_idx [NG];

    // Per-step registers
    logic [SW-1:0] r_slot;
    logic          r_fin;
    logic [BW-1:0] r_orig;

    // Result staging
    logic [rrqs_pkg::ID_W-1:0]    r_res_id;
    logic [rrqs_pkg::SLICE_W-1:0] r_res_slice;
    logic                         r_res_fin;
    logic                         r_res_empty;
    logic                         r_res_full;

    // Output register
    logic                         r_m_tvalid;
    logic [rrqs_pkg::TDATA_W-1:0] r_m_tdata;
    logic [rrqs_pkg::TUSER_W-1:0] r_m_tuser;

    // Group scan results
    logic [NP-1:0]  act_pad;
    logic [NP-1:0]  hi_pad;
    logic           g_hi_any [NG];
    logic [GIW-1:0] g_hi_idx [NG];
    logic           g_al_any [NG];
    logic [GIW-1:0] g_al_idx [NG];

    // Selection
    logic          found;
    logic [SW-1:0] sel_slot;

    // Memory
    logic              mem_wr_en;
    logic [SW-1:0]     mem_wr_addr;
    logic [2*BW-1:0]   mem_wr_data;
    logic [2*BW-1:0]   mem_rd_data;

    // Execute arithmetic
    logic [BW-1:0]                rem;
    logic [BW-1:0]                orig;
    logic [rrqs_pkg::SLICE_W-1:0] slice;
    logic [TW:0]                  time_sum;
    logic [TW-1:0]                time_new;
    logic [BW-1:0]                rem_new;
    logic [TW-1:0]                wait_amt;
    logic                         full;

    // Scan each group of eight flags for its lowest set bit
    always_comb begin
        act_pad = NP'(r_active);
        for (int s = 0; s < NP; s++) begin
            hi_pad[s] = act_pad[s] && (s > int'(r_cur));
        end
        for (int g = 0; g < NG; g++) begin
            g_hi_any[g] = 1'b0;
            g_hi_idx[g] = '0;
            g_al_any[g] = 1'b0;
            g_al_idx[g] = '0;
            for (int b = rrqs_pkg::GRP_W - 1; b >= 0; b--) begin
                if (hi_pad[g*rrqs_pkg::GRP_W + b]) begin
                    g_hi_any[g] = 1'b1;
                    g_hi_idx[g] = GIW'(b);
                end
                if (act_pad[g*rrqs_pkg::GRP_W + b]) begin
                    g_al_any[g] = 1'b1;
                    g_al_idx[g] = GIW'(b);
                end
            end
        end
    end

    // Capture the group scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.find) begin
            for (int g = 0; g < NG; g++) begin
                r_ghi_any[g] <= g_hi_any[g];
                r_ghi_idx[g] <= g_hi_idx[g];
                r_gal_any[g] <= g_al_any[g];
                r_gal_idx[g] <= g_al_idx[g];
            end
        end
    end

    // Pick the first group: above the current slot first, then wrap
    always_comb begin
        int  hi_slot;
        int  al_slot;
        logic hi_found;
        logic al_found;
        hi_slot  = 0;
        al_slot  = 0;
        hi_found = 1'b0;
        al_found = 1'b0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_ghi_any[g]) begin
                hi_found = 1'b1;
                hi_slot  = g * rrqs_pkg::GRP_W + int'(r_ghi_idx[g]);
            end
            if (r_gal_any[g]) begin
                al_found = 1'b1;
                al_slot  = g * rrqs_pkg::GRP_W + int'(r_gal_idx[g]);
            end
        end
        found    = hi_found || al_found;
        sel_slot = hi_found ? SW'(hi_slot) : SW'(al_slot);
    end

    // Slice arithmetic on the entry read back from the table
    always_comb begin
        rem      = mem_rd_data[BW-1:0];
        orig     = mem_rd_data[2*BW-1:BW];
        slice    = (rem > BW'(i_quantum)) ? i_quantum : rem[rrqs_pkg::SLICE_W-1:0];
        time_sum = {1'b0, r_time} + (TW+1)'(slice);
        time_new = (time_sum > (TW+1)'(rrqs_pkg::TIME_MAX)) ? rrqs_pkg::TIME_MAX
                                                             : time_sum[TW-1:0];
        rem_new  = rem - BW'(slice);
        wait_amt = r_time - TW'(r_orig);
        full     = (r_count == CW'(MAX_TASKS));
    end

    // Table write port: add writes both halves, execute writes back the remainder
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_slot;
        mem_wr_data = {orig, rem_new};
        if (i_cmd.do_add && !full) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = r_count[SW-1:0];
            mem_wr_data = {r_burst, r_burst};
        end else if (i_cmd.exec) begin
            mem_wr_en = 1'b1;
        end
    end

    rrqs_ram #(
        .WIDTH (2 * BW),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (i_cmd.sel),
        .i_rd_addr (sel_slot),
        .o_rd_data (mem_rd_data)
    );

    // Latch the incoming burst
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_burst <= i_burst;
        end
    end

    // Scheduler state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_started <= '0;
            r_count   <= '0;
            r_cur     <= SW'(MAX_TASKS - 1);
            r_time    <= '0;
            r_resp    <= '0;
            r_turn    <= '0;
            r_wait    <= '0;
        end else begin
            if (i_cmd.do_add && !full) begin
                r_active[r_count[SW-1:0]]  <= 1'b1;
                r_started[r_count[SW-1:0]] <= 1'b0;
                r_count                    <= r_count + CW'(1);
            end
            if (i_cmd.exec) begin
                r_cur  <= r_slot;
                r_time <= time_new;
                if (!r_started[r_slot]) begin
                    r_started[r_slot] <= 1'b1;
                    r_resp <= rrqs_pkg::sat_add32(r_resp, UW'(r_time));
                end
                if (rem_new == '0) begin
                    r_active[r_slot] <= 1'b0;
                end
            end
            if (i_cmd.acc && r_fin) begin
                r_turn <= rrqs_pkg::sat_add32(r_turn, UW'(r_time));
                if (r_time > TW'(r_orig)) begin
                    r_wait <= rrqs_pkg::sat_add32(r_wait, UW'(wait_amt));
                end
            end
        end
    end

    // Per-step values and result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_add) begin
            r_res_id    <= full ? '0 : rrqs_pkg::ID_W'(r_count);
            r_res_slice <= '0;
            r_res_fin   <= 1'b0;
            r_res_empty <= 1'b0;
            r_res_full  <= full;
        end
        if (i_cmd.sel) begin
            r_slot      <= sel_slot;
            r_res_id    <= '0;
            r_res_slice <= '0;
            r_res_fin   <= 1'b0;
            r_res_empty <= !found;
            r_res_full  <= 1'b0;
        end
        if (i_cmd.exec) begin
            r_fin       <= (rem_new == '0);
            r_orig      <= orig;
            r_res_id    <= rrqs_pkg::ID_W'(r_slot);
            r_res_slice <= slice;
            r_res_fin   <= (rem_new == '0);
        end
    end

    // Output register: load when free, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_m_tdata <= {5'b0, rrqs_pkg::COUNT_W'(r_count), r_wait, r_turn, r_resp,
                          r_time, r_res_slice, r_res_id};
            r_m_tuser <= {r_res_full, r_res_empty, r_res_fin};
        end
    end

    assign o_status.found    = found;
    assign o_status.out_free = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid        = r_m_tvalid;
    assign o_m_tdata         = r_m_tdata;
    assign o_m_tuser         = r_m_tuser;

`include "round_robin_quantum_scheduler_assert.svh"

    `RRQS_ASSERT_NXT(a_slice_in_quantum, i_cmd.exec, r_res_slice <= i_quantum)
    `RRQS_ASSERT_NXT(a_picked_is_active, i_cmd.sel && found, r_active[r_slot])
    `RRQS_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(MAX_TASKS))

endmodule

### hdl/round_robin_quantum_scheduler.sv
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler
// Task table with fixed-quantum time slices and saturating time totals.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  s_*       in         i_s_tvalid/o_s_tready   action (tuser), burst (tdata)
//  m_*       out        o_m_tvalid/i_m_tready   task/slice/time/sums, flags
//  apb       in         psel/penable/pwrite     quantum at byte address 0
//
//  An add item goes through the add state from accept to result; a step
//  item goes through a registered scan of the active flags in groups of
//  eight, a group pick with table read, the slice update and the totals
//  update. A step that finds no active task skips both updates.
//  Reset is synchronous and active low; the table needs no clearing pass.
//  A stalled result holds in the output register; the next item is taken
//  and worked until its own result is ready to load.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler #(
    parameter int MAX_TASKS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [15:0] burst
    input  logic [15:0]                   i_s_tdata,
    // [0] action
    input  logic                          i_s_tuser,
    // Output stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [5:0] task_id, [13:6] slice_len, [35:14] elapsed_time,
    // [67:36] response_sum, [99:68] turnaround_sum, [131:100] wait_sum,
    // [138:132] task_count, [143:139] zero
    output logic [rrqs_pkg::TDATA_W-1:0]  o_m_tdata,
    // [0] task_finished, [1] queue_empty, [2] table_full
    output logic [rrqs_pkg::TUSER_W-1:0]  o_m_tuser,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [rrqs_pkg::QUANT_W-1:0] r_quantum;
    rrqs_pkg::t_cmd               cmd;
    rrqs_pkg::t_status            status;
    logic                         cfg_wr;

    // Quantum register write
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= rrqs_pkg::QUANTUM_RESET;
        end else if (cfg_wr && (paddr[2] == rrqs_pkg::REG_QUANTUM)) begin
            r_quantum <= pwdata[rrqs_pkg::QUANT_W-1:0];
        end
    end

    // Register read
    assign prdata = (paddr[2] == rrqs_pkg::REG_QUANTUM) ? 32'(r_quantum) : '0;

    rrqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_action   (i_s_tuser),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    rrqs_dpath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_quantum  (r_quantum),
        .i_burst    (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

### tb/rrqs_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Round-robin scheduler slice tracker
// Predicts the result of every accepted item from its own copy of the task
// table, time and totals, and checks each delivered result against it.
// ----------------------------------------------------------------------------
package rrqs_tb_pkg;

    import rrqs_pkg::*;

    localparam int TASK_SLOTS = 64;

    typedef struct packed {
        logic [ID_W-1:0]    task_id;
        logic [SLICE_W-1:0] slice_len;
        logic               finished;
        logic               empty;
        logic               full;
        logic [TIME_W-1:0]  elapsed;
        logic [SUM_W-1:0]   response;
        logic [SUM_W-1:0]   turnaround;
        logic [SUM_W-1:0]   waiting;
        logic [COUNT_W-1:0] count;
    } slice_rec_t;

    class rr_slice_tracker;
        logic [QUANT_W-1:0] quantum;
        logic [BURST_W-1:0] remaining [TASK_SLOTS];
        logic [BURST_W-1:0] original [TASK_SLOTS];
        bit                 started [TASK_SLOTS];
        bit                 active [TASK_SLOTS];
        logic [COUNT_W-1:0] added;
        logic [ID_W-1:0]    cur_slot;
        logic [TIME_W-1:0]  now;
        logic [SUM_W-1:0]   resp_tot;
        logic [SUM_W-1:0]   turn_tot;
        logic [SUM_W-1:0]   wait_tot;
        slice_rec_t         expected_slices [$];
        int                 fail_count;

        function new();
            quantum  = QUANTUM_RESET;
            added    = '0;
            cur_slot = ID_W'(TASK_SLOTS - 1);
            now      = '0;
            resp_tot = '0;
            turn_tot = '0;
            wait_tot = '0;
            fail_count = 0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                started[i] = 1'b0;
                active[i]  = 1'b0;
            end
        endfunction

        function void set_quantum(logic [QUANT_W-1:0] q);
            quantum = q;
        endfunction

        // Add with clamp at the top of the 32-bit range
        function logic [SUM_W-1:0] clamp_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
            logic [SUM_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
        endfunction

        function int pending();
            return expected_slices.size();
        endfunction

        // Work out the result of one accepted item and queue it
        function void predict_item(logic action, logic [BURST_W-1:0] burst);
            slice_rec_t      r;
            logic [ID_W-1:0] s;
            logic [ID_W-1:0] pick;
            bit              found;
            logic [BURST_W-1:0] len;
            logic [TIME_W:0] t;
            r = '0;
            found = 0;
            pick = '0;
            if (action == ACT_ADD) begin
                if (added >= TASK_SLOTS) begin
                    r.full = 1'b1;
                end else begin
                    remaining[added] = burst;
                    original[added]  = burst;
                    started[added]   = 1'b0;
                    active[added]    = 1'b1;
                    r.task_id = added[ID_W-1:0];
                    added = added + 1'b1;
                end
            end else begin
                // Rotate from the slot after the current one
                for (int k = 1; k <= TASK_SLOTS; k++) begin
                    s = cur_slot + ID_W'(k);
                    if (!found && active[s]) begin
                        pick  = s;
                        found = 1;
                    end
                end
                if (!found) begin
                    r.empty = 1'b1;
                end else begin
                    cur_slot = pick;
                    if (!started[pick]) begin
                        resp_tot = clamp_add(resp_tot, SUM_W'(now));
                        started[pick] = 1'b1;
                    end
                    len = (remaining[pick] > quantum) ? BURST_W'(quantum) : remaining[pick];
                    t = {1'b0, now} + (TIME_W + 1)'(len);
                    now = (t > TIME_MAX) ? TIME_MAX : t[TIME_W-1:0];
                    remaining[pick] = remaining[pick] - len;
                    if (remaining[pick] == 0) begin
                        active[pick] = 1'b0;
                        turn_tot = clamp_add(turn_tot, SUM_W'(now));
                        if (now > original[pick])
                            wait_tot = clamp_add(wait_tot, SUM_W'(now - original[pick]));
                        r.finished = 1'b1;
                    end
                    r.task_id   = pick;
                    r.slice_len = len[SLICE_W-1:0];
                end
            end
            r.elapsed    = now;
            r.response   = resp_tot;
            r.turnaround = turn_tot;
            r.waiting    = wait_tot;
            r.count      = added;
            expected_slices.push_back(r);
        endfunction

        // Compare one delivered result with the oldest expectation
        function void check_result(logic [TDATA_W-1:0] data, logic [TUSER_W-1:0] user);
            slice_rec_t  e;
            logic [63:0] want [10];
            logic [63:0] got [10];
            string       names [10];
            if (expected_slices.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: tdata=%h tuser=%b", data, user);
                return;
            end
            e = expected_slices.pop_front();
            names = '{"task_id", "slice_len", "task_finished", "queue_empty", "table_full",
                      "elapsed_time", "response_sum", "turnaround_sum", "wait_sum",
                      "task_count"};
            want = '{64'(e.task_id), 64'(e.slice_len), 64'(e.finished), 64'(e.empty),
                     64'(e.full), 64'(e.elapsed), 64'(e.response), 64'(e.turnaround),
                     64'(e.waiting), 64'(e.count)};
            got  = '{64'(data[5:0]), 64'(data[13:6]), 64'(user[0]), 64'(user[1]),
                     64'(user[2]), 64'(data[35:14]), 64'(data[67:36]), 64'(data[99:68]),
                     64'(data[131:100]), 64'(data[138:132])};
            for (int i = 0; i < 10; i++) begin
                if (want[i] !== got[i]) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch on %s: expected %0d, got %0d",
                                 names[i], want[i], got[i]);
                end
            end
        endfunction

        // Count expectations that never got a result
        function void close_out();
            if (expected_slices.size() != 0) begin
                fail_count += expected_slices.size();
                $display("%0d results never arrived", expected_slices.size());
            end
        endfunction
    endclass

endpackage

### tb/round_robin_quantum_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler testbench
// Drives add and step items with random gaps and output stalls, rewrites
// the quantum between phases, and checks every result against a predictor.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler_tb;

    import rrqs_pkg::*;
    import rrqs_tb_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int TAIL_CYCLES = 20;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [15:0]          i_s_tdata = '0;
    logic                 i_s_tuser = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b1;
    logic [TDATA_W-1:0]   o_m_tdata;
    logic [TUSER_W-1:0]   o_m_tuser;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    rr_slice_tracker tracker = new();
    bit              no_gaps = 0;
    int              rx_wait = 0;
    int              idle_cycles = 0;

    round_robin_quantum_scheduler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 9);
    endfunction

    // Send one item, then hold off for a drawn gap
    task automatic send_item(logic action, logic [15:0] burst);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= burst;
        i_s_tuser  <= action;
        do @(posedge i_clk); while (!o_s_tready);
        tracker.predict_item(action, burst);
        gap = draw_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the input until every expected result has come out
    task automatic quiesce();
        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_quantum(logic [7:0] q);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_QUANTUM);
        pwdata  <= 32'(q);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_quantum(q);
    endtask

    // Check results and stall the output side per item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                tracker.check_result(o_m_tdata, o_m_tuser);
                rx_wait = draw_gap();
                if (rx_wait > 0)
                    i_m_tready <= 1'b0;
            end else if (!i_m_tready) begin
                if (rx_wait <= 1)
                    i_m_tready <= 1'b1;
                rx_wait = rx_wait - 1;
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (psel && penable) || !i_rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        logic       act;
        logic [15:0] burst;
        logic [7:0] q;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue, zero and full bursts, rotation at reset quantum
        send_item(ACT_STEP, 16'h0000);
        send_item(ACT_ADD, 16'h0000);
        send_item(ACT_ADD, 16'hFFFF);
        send_item(ACT_ADD, 16'h0001);
        send_item(ACT_ADD, 16'd25);
        repeat (8) send_item(ACT_STEP, 16'hFFFF);
        quiesce();
        write_quantum(8'hFF);
        repeat (3) send_item(ACT_STEP, 16'h0000);
        quiesce();
        // Zero quantum: only a zero-burst task can finish
        write_quantum(8'h00);
        send_item(ACT_STEP, 16'h0000);
        send_item(ACT_ADD, 16'h0000);
        repeat (3) send_item(ACT_STEP, 16'h0000);
        quiesce();
        write_quantum(8'h01);
        repeat (3) send_item(ACT_STEP, 16'h0000);

        // Random phases at several quantum settings
        for (int ph = 0; ph < 8; ph++) begin
            quiesce();
            case (ph)
                0: q = 8'd1;
                1: q = 8'd255;
                2, 5: q = 8'($urandom_range(2, 12));
                default: q = 8'($urandom_range(1, 255));
            endcase
            write_quantum(q);
            no_gaps = (ph == 3 || ph == 6);
            repeat (175) begin
                act = ($urandom_range(0, 9) == 0) ? ACT_ADD : ACT_STEP;
                if ($urandom_range(0, 5) == 0)
                    burst = 16'($urandom_range(0, 65535));
                else
                    burst = 16'($urandom_range(0, 60));
                send_item(act, burst);
            end
        end

        no_gaps = 0;
        quiesce();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        tracker.close_out();
        if (tracker.fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
